@@ rtl/cse_pkg.sv @@
// Shared types and constants of the cosine similarity engine.
`default_nettype none
package cse_pkg;
  localparam int unsigned MaxLen = 1024;
  localparam int unsigned CntW = $clog2(MaxLen + 1);
  localparam int unsigned DotW = 42;
  localparam int unsigned NrmW = 41;
  localparam int unsigned ProdW = 2 * NrmW;
  localparam int unsigned RootW = NrmW;
  localparam int unsigned NumW = DotW + 14;
  localparam int unsigned RootStepW = $clog2(RootW);
  localparam int unsigned DivStepW = $clog2(NumW);
  localparam logic [15:0] QOne = 16'd16384;

  typedef struct packed {
    logic signed [15:0] elem_a;
    logic signed [15:0] elem_b;
    logic               last;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] similarity;
    logic               identical;
    logic               zero_norm;
    logic               overflow;
  } out_beat_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic acc_en;
    logic latch;
    logic mul_en;
    logic root_init;
    logic root_step;
    logic div_init;
    logic div_step;
    logic fin;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mode_match;
    logic zero_norm;
  } stat_t;
endpackage
`default_nettype wire

@@ rtl/cosine_similarity_engine_unit.sv @@
// Top level of the cosine similarity engine.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | in_beat_i  (cse_pkg::in_beat_t)
//  out     | output    | out_valid/out_stall| out_beat_o (cse_pkg::out_beat_t)
//  cfg     | input     | cfg_we_i           | cfg_wdata_i (mode)
//
// A beat without the last mark is taken without a stall. A last beat starts the
// result sequence: multiply, sum, a 41 step square root, divider set up, a
// 56 step restoring divide and a finish state; match mode skips sum and root,
// and a zero norm skips from sum to finish.
// Input is stalled meanwhile.
// Reset clears the accumulators, mode and the sequencer at once.
// A result beat is held until out_stall drops; then the next input is taken.
`default_nettype none
module cosine_similarity_engine_unit (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_wdata_i,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire cse_pkg::in_beat_t   in_beat_i,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output cse_pkg::out_beat_t       out_beat_o
);
  logic mode_q;
  cse_pkg::cmd_t cmd;
  cse_pkg::stat_t stat;

  // The mode register is sampled by the datapath when the last beat lands.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mode_q <= 1'b0;
    else if (cfg_we_i) mode_q <= cfg_wdata_i;
  end

  cse_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall,
    .in_last_i(in_beat_i.last), .stat_i(stat), .cmd_o(cmd)
  );

  cse_datapath u_dp (
    .clk_i, .rst_ni, .mode_i(mode_q), .in_i(in_beat_i), .cmd_i(cmd),
    .stat_o(stat), .res_o(out_beat_o)
  );

`ifndef ASSERT_OFF
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> in_stall) else $error("input open while result pending");
  a_zero_norm_sim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_beat_o.zero_norm) |-> out_beat_o.similarity == '0)
    else $error("zero norm with nonzero similarity");
  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && !in_stall && in_beat_i.last) |=> in_stall)
    else $error("sequencer did not start on last beat");
`endif
endmodule
`default_nettype wire

@@ rtl/cse_datapath.sv @@
// Accumulators, product multiplier, square root and divider of the engine.
`default_nettype none
module cse_datapath (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  mode_i,
  input  wire cse_pkg::in_beat_t     in_i,
  input  wire cse_pkg::cmd_t         cmd_i,
  output cse_pkg::stat_t             stat_o,
  output cse_pkg::out_beat_t         res_o
);
  localparam int unsigned CntW = cse_pkg::CntW;
  localparam int unsigned NrmW = cse_pkg::NrmW;
  localparam int unsigned DotW = cse_pkg::DotW;
  localparam int unsigned PW   = cse_pkg::ProdW;
  localparam int unsigned RW   = cse_pkg::RootW;
  localparam int unsigned NW   = cse_pkg::NumW;

  logic signed [DotW-1:0] dot_q;
  logic [NrmW-1:0] na_q, nb_q;
  logic [CntW-1:0] mc_q, pc_q;
  logic eq_q, ovf_q;

  // Latched copies for the result computation.
  logic [NrmW-1:0] la_q, lb_q;
  logic neg_q, mode_q, eqr_q, ovfr_q;
  logic [PW-1:0] prod_q;
  logic [RW-1:0] root_q;
  logic [RW:0] rrem_q;
  logic [NW-1:0] rem_q, quo_q, num_q;
  logic [RW:0] dvs_q;
  logic [NW-1:0] dvs_lo;
  cse_pkg::out_beat_t res_q;

  logic signed [31:0] pab, paa, pbb;
  logic take;
  logic [RW+2:0] rpart;
  logic [RW+3:0] rtrial;
  logic [NW:0] trial;
  logic [DotW-1:0] mag;
  logic [NW-1:0] qclamp;

  assign pab = in_i.elem_a * in_i.elem_b;
  assign paa = in_i.elem_a * in_i.elem_a;
  assign pbb = in_i.elem_b * in_i.elem_b;
  assign take = pc_q < CntW'(cse_pkg::MaxLen);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q <= '0; na_q <= '0; nb_q <= '0; mc_q <= '0; pc_q <= '0;
      eq_q <= 1'b1; ovf_q <= 1'b0;
    end else if (cmd_i.acc_en) begin
      if (cmd_i.latch) begin
        dot_q <= '0; na_q <= '0; nb_q <= '0; mc_q <= '0; pc_q <= '0;
        eq_q <= 1'b1; ovf_q <= 1'b0;
      end else if (take) begin
        dot_q <= dot_q + DotW'(pab);
        na_q  <= na_q + NrmW'($unsigned(paa));
        nb_q  <= nb_q + NrmW'($unsigned(pbb));
        mc_q  <= mc_q + CntW'(in_i.elem_a == in_i.elem_b);
        eq_q  <= eq_q & (in_i.elem_a == in_i.elem_b);
        pc_q  <= pc_q + 1'b1;
      end else begin
        ovf_q <= 1'b1;
      end
    end
  end

  // The last beat is folded in combinationally when latching.
  logic signed [DotW-1:0] dot_f;
  logic [NrmW-1:0] na_f, nb_f;
  logic [CntW-1:0] mc_f, pc_f;
  logic eq_f, ovf_f;
  always_comb begin
    dot_f = dot_q; na_f = na_q; nb_f = nb_q; mc_f = mc_q; pc_f = pc_q;
    eq_f = eq_q; ovf_f = ovf_q;
    if (take) begin
      dot_f = dot_q + DotW'(pab);
      na_f  = na_q + NrmW'($unsigned(paa));
      nb_f  = nb_q + NrmW'($unsigned(pbb));
      mc_f  = mc_q + CntW'(in_i.elem_a == in_i.elem_b);
      eq_f  = eq_q & (in_i.elem_a == in_i.elem_b);
      pc_f  = pc_q + 1'b1;
    end else begin
      ovf_f = 1'b1;
    end
  end

  assign mag = dot_f[DotW-1] ? DotW'(-dot_f) : DotW'(dot_f);
  // Digit by digit square root: two radicand bits enter the partial remainder
  // each step and one root bit is decided by a compare and subtract.
  assign rpart = {rrem_q, prod_q[PW-1 -: 2]};
  assign rtrial = {1'b0, rpart} - (RW+4)'({root_q, 2'b01});
  assign dvs_lo = NW'(dvs_q);
  assign trial = {rem_q, quo_q[NW-1]} - {1'b0, dvs_lo};
  assign qclamp = (quo_q > NW'(cse_pkg::QOne)) ? NW'(cse_pkg::QOne) : quo_q;

  // Product is split over partial products of the two 41 bit norms.
  logic [20:0] a0, b0;
  logic [19:0] a1, b1;
  logic [41:0] p00, p11;
  logic [40:0] p01, p10;
  logic [41:0] s00_q, s11_q;
  logic [40:0] s01_q, s10_q;
  assign {a1, a0} = la_q;
  assign {b1, b0} = lb_q;
  assign p00 = a0 * b0;
  assign p01 = a0 * b1;
  assign p10 = a1 * b0;
  assign p11 = 42'(a1 * b1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      la_q <= na_f; lb_q <= nb_f;
      neg_q <= dot_f[DotW-1];
      num_q <= {mag, 14'd0};
      mode_q <= mode_i; eqr_q <= eq_f; ovfr_q <= ovf_f;
      if (mode_i) begin
        num_q <= NW'({mc_f, 14'd0});
        dvs_q <= (RW+1)'(pc_f);
      end
    end
    if (cmd_i.mul_en) begin
      s00_q <= p00; s01_q <= p01; s10_q <= p10; s11_q <= p11;
    end
    if (cmd_i.root_init) begin
      prod_q <= PW'(s00_q) + (PW'(s01_q) << 21) + (PW'(s10_q) << 21)
              + (PW'(s11_q) << 42);
      root_q <= '0;
      rrem_q <= '0;
    end
    if (cmd_i.root_step) begin
      prod_q <= prod_q << 2;
      if (!rtrial[RW+3]) begin
        rrem_q <= rtrial[RW:0]; root_q <= {root_q[RW-2:0], 1'b1};
      end else begin
        rrem_q <= rpart[RW:0]; root_q <= {root_q[RW-2:0], 1'b0};
      end
    end
    if (cmd_i.div_init) begin
      rem_q <= '0; quo_q <= num_q;
      if (!mode_q) dvs_q <= {1'b0, root_q};
    end
    if (cmd_i.div_step) begin
      if (!trial[NW]) begin
        rem_q <= trial[NW-1:0]; quo_q <= {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[NW-2:0], quo_q[NW-1]}; quo_q <= {quo_q[NW-2:0], 1'b0};
      end
    end
    if (cmd_i.fin) begin
      res_q.identical <= eqr_q;
      res_q.overflow <= ovfr_q;
      res_q.zero_norm <= stat_o.zero_norm;
      if (stat_o.zero_norm) res_q.similarity <= '0;
      else if (mode_q) res_q.similarity <= dvs_q == '0 ? '0 : 16'(quo_q);
      else res_q.similarity <= neg_q ? 16'(-qclamp) : 16'(qclamp);
    end
  end

  assign stat_o.mode_match = mode_q;
  assign stat_o.zero_norm = !mode_q && (la_q == '0 || lb_q == '0);
  assign res_o = res_q;
endmodule
`default_nettype wire

@@ rtl/cse_ctrl.sv @@
// Sequencer of the engine: accumulate, multiply, root, divide, deliver.
`default_nettype none
module cse_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire logic              in_last_i,
  input  wire cse_pkg::stat_t    stat_i,
  output cse_pkg::cmd_t          cmd_o
);
  typedef enum logic [2:0] {
    SAcc, SMul, SSum, SRoot, SDivI, SDiv, SFin, SOut
  } state_e;

  state_e state_q;
  logic [cse_pkg::RootStepW-1:0] rb_q;
  logic [cse_pkg::DivStepW-1:0] dc_q;
  logic acc;

  assign in_stall = state_q != SAcc;
  assign acc = in_valid && state_q == SAcc;
  assign out_valid = state_q == SOut;

  always_comb begin
    cmd_o = '0;
    cmd_o.acc_en = acc;
    cmd_o.latch = acc && in_last_i;
    cmd_o.mul_en = state_q == SMul;
    cmd_o.root_init = state_q == SSum;
    cmd_o.root_step = state_q == SRoot;
    cmd_o.div_init = state_q == SDivI;
    cmd_o.div_step = state_q == SDiv;
    cmd_o.fin = state_q == SFin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SAcc; rb_q <= '0; dc_q <= '0;
    end else begin
      unique case (state_q)
        SAcc: if (acc && in_last_i) state_q <= SMul;
        SMul: state_q <= stat_i.mode_match ? SDivI : SSum;
        SSum: begin
          if (stat_i.zero_norm) state_q <= SFin;
          else begin
            state_q <= SRoot;
            rb_q <= cse_pkg::RootStepW'(cse_pkg::RootW - 1);
          end
        end
        SRoot: begin
          if (rb_q == '0) state_q <= SDivI;
          else rb_q <= rb_q - 1'b1;
        end
        SDivI: begin
          state_q <= SDiv;
          dc_q <= cse_pkg::DivStepW'(cse_pkg::NumW - 1);
        end
        SDiv: begin
          if (dc_q == '0) state_q <= SFin;
          else dc_q <= dc_q - 1'b1;
        end
        SFin: state_q <= SOut;
        SOut: if (!out_stall) state_q <= SAcc;
        default: state_q <= SAcc;
      endcase
    end
  end
endmodule
`default_nettype wire
